### rtl/core/bf3_pkg.sv
// Shared types and constants of the 3x3 box mean filter.
package bf3_pkg;

	// Line store depth, one entry per pixel column
	localparam int LINE_DEPTH = 2048;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int MAX_HEIGHT = 4096;
	localparam int MIN_SIZE   = 3;

	// Field widths
	localparam int PIX_W  = 8;
	localparam int WID_W  = 12;
	localparam int HGT_W  = 13;
	localparam int ROW_W  = 12;
	localparam int COL_W  = 11;
	localparam int CSUM_W = 10;   // sum of three pixels
	localparam int WSUM_W = 12;   // sum of nine pixels

	// floor(x / 9) = (x * 7282) >> 16, exact for x below 32768
	localparam int RECIP_9     = 7282;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Position and end-of-frame mark that travel with a result
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} tag_t;

	// Window sum leaving the line store unit
	typedef struct packed {
		logic              valid;
		tag_t              tag;
		logic [WSUM_W-1:0] sum;
	} sum_t;

	// One queued result
	typedef struct packed {
		logic [PIX_W-1:0] mean;
		tag_t             tag;
	} res_t;

endpackage

### rtl/core/bf3_stream_ifs.sv
// Stream interfaces of the filter: pixel input and result output.
interface bf3_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface bf3_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  mean_value;
	logic [11:0] out_row;
	logic [10:0] out_col;
	logic        frame_last;

	modport source (output valid, output mean_value, output out_row, output out_col,
		output frame_last, input ready);
	modport sink   (input valid, input mean_value, input out_row, input out_col,
		input frame_last, output ready);
endinterface

### rtl/core/bf3_window.sv
// Line store memory and 3x3 window column sums.
module bf3_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [bf3_pkg::PIX_W-1:0]   pixel,
	input  logic [bf3_pkg::ADDR_W-1:0]  addr,
	input  logic                        emit,
	input  bf3_pkg::tag_t               tag,
	output bf3_pkg::sum_t               sum_out,
	output logic [1:0]                  inflight
);

	// Each entry holds {two rows above, one row above} for a column
	logic [2*bf3_pkg::PIX_W-1:0] line_mem [bf3_pkg::LINE_DEPTH];

	logic                        v_s1;
	logic                        emit_s1;
	logic [bf3_pkg::PIX_W-1:0]   px_s1;
	logic [bf3_pkg::ADDR_W-1:0]  addr_s1;
	bf3_pkg::tag_t               tag_s1;
	logic [2*bf3_pkg::PIX_W-1:0] rd_s1;

	logic [bf3_pkg::CSUM_W-1:0]  cs1_q;
	logic [bf3_pkg::CSUM_W-1:0]  cs2_q;
	logic [bf3_pkg::CSUM_W-1:0]  col_sum;

	logic                        v_s2;
	bf3_pkg::tag_t               tag_s2;
	logic [bf3_pkg::CSUM_W-1:0]  a_s2;
	logic [bf3_pkg::CSUM_W-1:0]  b_s2;
	logic [bf3_pkg::CSUM_W-1:0]  c_s2;

	logic                        v_s3;
	bf3_pkg::tag_t               tag_s3;
	logic [bf3_pkg::WSUM_W-1:0]  sum_s3;

	// Read the column at acceptance; write it back in the next cycle.
	// Consecutive pixels never share a column, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (take) begin
			rd_s1 <= line_mem[addr];
		end
		if (v_s1) begin
			line_mem[addr_s1] <= {rd_s1[bf3_pkg::PIX_W-1:0], px_s1};
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			px_s1   <= pixel;
			addr_s1 <= addr;
			emit_s1 <= emit;
			tag_s1  <= tag;
		end
	end

	// Sum of the newest column: upper, lower and incoming pixel
	assign col_sum = bf3_pkg::CSUM_W'(rd_s1[2*bf3_pkg::PIX_W-1:bf3_pkg::PIX_W])
		+ bf3_pkg::CSUM_W'(rd_s1[bf3_pkg::PIX_W-1:0])
		+ bf3_pkg::CSUM_W'(px_s1);

	// Shift the window column sums by one column per pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs1_q <= '0;
			cs2_q <= '0;
		end else if (v_s1) begin
			cs1_q <= cs2_q;
			cs2_q <= col_sum;
		end
	end

	// Stage 2: hold the three column sums of the full window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && emit_s1) begin
			a_s2   <= cs1_q;
			b_s2   <= cs2_q;
			c_s2   <= col_sum;
			tag_s2 <= tag_s1;
		end
		if (v_s2) begin
			sum_s3 <= bf3_pkg::WSUM_W'(a_s2) + bf3_pkg::WSUM_W'(b_s2)
				+ bf3_pkg::WSUM_W'(c_s2);
			tag_s3 <= tag_s2;
		end
	end

	assign sum_out.valid = v_s3;
	assign sum_out.tag   = tag_s3;
	assign sum_out.sum   = sum_s3;
	assign inflight      = 2'(v_s1) + 2'(v_s2) + 2'(v_s3);

endmodule

### rtl/core/bf3_out_fifo.sv
// Result queue that decouples the filter pipeline from the receiver.
module bf3_out_fifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  bf3_pkg::res_t                  push_data,
	output logic [bf3_pkg::FIFO_PTR_W:0]   count,
	bf3_res_if.source                      res
);

	bf3_pkg::res_t                 entries [bf3_pkg::FIFO_DEPTH];
	logic [bf3_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [bf3_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [bf3_pkg::FIFO_PTR_W:0]   count_q;
	logic                           pop;
	bf3_pkg::res_t                  head;

	assign pop = res.valid && res.ready;

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Present the oldest entry
	assign head           = entries[rd_ptr_q];
	assign res.valid      = (count_q != '0);
	assign res.mean_value = head.mean;
	assign res.out_row    = head.tag.row;
	assign res.out_col    = head.tag.col;
	assign res.frame_last = head.tag.last;
	assign count          = count_q;

endmodule

### rtl/core/box_filter_3x3.sv
// Top level of the 3x3 box mean filter.
//
// Pixels enter on the pixels channel in raster order, one per transaction.
// For every interior pixel the block sends one transaction on the results
// channel: the truncated mean of the 3x3 neighbourhood, the row and column
// of the centre pixel, and frame_last on the final interior result of the
// frame. Border pixels give no result.
// Frame size is set through cfg_write/cfg_index/cfg_data while the block is
// idle; sizes are clamped to 3..2048 columns and 3..4096 rows.
// Throughput: one pixel per cycle while the result queue has room. A result
// passes the line store read, column sum and window sum registers before it
// enters the output queue; the line store is read at acceptance and written in the
// next cycle on a single-port-per-side memory, which sets the one pixel per cycle rate.
// A stalled receiver fills an eight-entry result queue; pixels are still
// accepted as long as the queue has room for everything in flight.
// Reset clears the counters, the window and the queue and sets the size to
// 640 by 480; line store contents are left as they are.
module box_filter_3x3 (
	input  logic                              clk,
	input  logic                              arst_n,
	bf3_pix_if.sink                           pixels,
	bf3_res_if.source                         results,
	input  logic                              cfg_write,
	input  logic [bf3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bf3_pkg::CFG_DAT_W-1:0]     cfg_data
);

	logic [bf3_pkg::WID_W-1:0]      width_q;
	logic [bf3_pkg::HGT_W-1:0]      height_q;
	logic [bf3_pkg::ROW_W-1:0]      row_q;
	logic [bf3_pkg::COL_W-1:0]      col_q;
	logic [bf3_pkg::WID_W-1:0]      w_eff;
	logic [bf3_pkg::HGT_W-1:0]      h_eff;
	logic [bf3_pkg::COL_W-1:0]      w_last;
	logic [bf3_pkg::ROW_W-1:0]      h_last;
	logic                           take;
	logic                           emit;
	bf3_pkg::tag_t                  tag;
	bf3_pkg::sum_t                  win_sum;
	logic [1:0]                     inflight;
	logic [bf3_pkg::FIFO_PTR_W:0]   fifo_count;
	logic [bf3_pkg::FIFO_PTR_W+1:0] occupancy;
	logic [bf3_pkg::WSUM_W+bf3_pkg::RECIP_W-1:0] product;
	bf3_pkg::res_t                  push_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bf3_pkg::WID_W'(640);
			height_q <= bf3_pkg::HGT_W'(480);
		end else if (cfg_write) begin
			unique case (cfg_index)
				bf3_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[bf3_pkg::WID_W-1:0];
				end
				bf3_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp the frame size and find the last column and row
	always_comb begin
		priority if (width_q < bf3_pkg::WID_W'(bf3_pkg::MIN_SIZE)) begin
			w_eff = bf3_pkg::WID_W'(bf3_pkg::MIN_SIZE);
		end else if (width_q > bf3_pkg::WID_W'(bf3_pkg::LINE_DEPTH)) begin
			w_eff = bf3_pkg::WID_W'(bf3_pkg::LINE_DEPTH);
		end else begin
			w_eff = width_q;
		end
		priority if (height_q < bf3_pkg::HGT_W'(bf3_pkg::MIN_SIZE)) begin
			h_eff = bf3_pkg::HGT_W'(bf3_pkg::MIN_SIZE);
		end else if (height_q > bf3_pkg::HGT_W'(bf3_pkg::MAX_HEIGHT)) begin
			h_eff = bf3_pkg::HGT_W'(bf3_pkg::MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign w_last = bf3_pkg::COL_W'(w_eff - 1'b1);
	assign h_last = bf3_pkg::ROW_W'(h_eff - 1'b1);

	// Accept while the queue has room for everything in flight
	assign occupancy = (bf3_pkg::FIFO_PTR_W+2)'(fifo_count)
		+ (bf3_pkg::FIFO_PTR_W+2)'(inflight);
	assign pixels.ready = occupancy < (bf3_pkg::FIFO_PTR_W+2)'(bf3_pkg::FIFO_DEPTH);
	assign take = pixels.valid && pixels.ready;

	// Interior test and result tag for the incoming pixel
	assign emit     = (row_q >= bf3_pkg::ROW_W'(2)) && (col_q >= bf3_pkg::COL_W'(2));
	assign tag.row  = row_q - 1'b1;
	assign tag.col  = col_q - 1'b1;
	assign tag.last = (row_q >= h_last) && (col_q >= w_last);

	// Raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			if (col_q >= w_last) begin
				col_q <= '0;
				if (row_q >= h_last) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	bf3_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.pixel    (pixels.pixel),
		.addr     (col_q),
		.emit     (emit),
		.tag      (tag),
		.sum_out  (win_sum),
		.inflight (inflight)
	);

	// Divide the window sum by nine through the reciprocal
	assign product = (bf3_pkg::WSUM_W+bf3_pkg::RECIP_W)'(win_sum.sum)
		* (bf3_pkg::WSUM_W+bf3_pkg::RECIP_W)'(bf3_pkg::RECIP_9);
	assign push_data.mean = product[bf3_pkg::RECIP_SHIFT +: bf3_pkg::PIX_W];
	assign push_data.tag  = win_sum.tag;

	bf3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (win_sum.valid),
		.push_data (push_data),
		.count     (fifo_count),
		.res       (results)
	);

	// Queue never overflows: credit covers every item in flight
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= (bf3_pkg::FIFO_PTR_W+2)'(bf3_pkg::FIFO_DEPTH))
		else $error("result queue occupancy exceeds its depth");

	// An accepted interior pixel always yields a push into the queue
	a_emit_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(take && emit) |-> ##3 win_sum.valid)
		else $error("interior pixel produced no result");

	// A border pixel never produces a result
	a_border_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !emit) |-> ##3 !win_sum.valid)
		else $error("border pixel produced a result");

	// Results never sit on the first row or column
	a_interior_tag: assert property (@(posedge clk) disable iff (!arst_n)
		win_sum.valid |-> (win_sum.tag.row != '0) && (win_sum.tag.col != '0))
		else $error("result tagged with a border position");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the 3x3 box mean filter: stream stimulus and result scoreboard.
module testbench;

	localparam int LONG_HOLD = 150;

	logic clk = 1'b0;
	logic arst_n;
	logic                          cfg_write;
	logic [bf3_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bf3_pkg::CFG_DAT_W-1:0] cfg_data;

	bf3_pix_if pix_if ();
	bf3_res_if res_if ();

	box_filter_3x3 u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix_if),
		.results   (res_if),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Pixels waiting to be sent and window means still to arrive
	logic [bf3_pkg::PIX_W-1:0] pixels_todo [$];
	bf3_pkg::res_t             means_due [$];
	int                        mismatches = 0;

	// Idle control shared by the main sequence and the channel processes
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned hold_req = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;

	// Filter state as the block should hold it
	logic [bf3_pkg::WID_W-1:0] line_w;
	logic [bf3_pkg::HGT_W-1:0] frame_h;
	logic [bf3_pkg::PIX_W-1:0] upper_line [bf3_pkg::LINE_DEPTH];
	logic [bf3_pkg::PIX_W-1:0] lower_line [bf3_pkg::LINE_DEPTH];
	bit                        upper_ok [bf3_pkg::LINE_DEPTH];
	bit                        lower_ok [bf3_pkg::LINE_DEPTH];
	logic [bf3_pkg::PIX_W-1:0] win [9];
	int unsigned               row_at;
	int unsigned               col_at;

	function automatic int unsigned eff_width(input logic [bf3_pkg::WID_W-1:0] v);
		if (v < bf3_pkg::MIN_SIZE) return bf3_pkg::MIN_SIZE;
		if (v > bf3_pkg::LINE_DEPTH) return bf3_pkg::LINE_DEPTH;
		return v;
	endfunction

	function automatic int unsigned eff_height(input logic [bf3_pkg::HGT_W-1:0] v);
		if (v < bf3_pkg::MIN_SIZE) return bf3_pkg::MIN_SIZE;
		if (v > bf3_pkg::MAX_HEIGHT) return bf3_pkg::MAX_HEIGHT;
		return v;
	endfunction

	// Advance the line stores and window by one pixel; queue the mean it yields
	task automatic shift_in_pixel(input logic [bf3_pkg::PIX_W-1:0] px);
		int unsigned w, h, total, k;
		logic [bf3_pkg::PIX_W-1:0] two_up, one_up;
		bf3_pkg::res_t r;
		w = eff_width(line_w);
		h = eff_height(frame_h);
		two_up = '0;
		one_up = '0;
		if (col_at < bf3_pkg::LINE_DEPTH) begin
			two_up = upper_line[col_at];
			one_up = lower_line[col_at];
			upper_line[col_at] = one_up;
			lower_line[col_at] = px;
			upper_ok[col_at] = lower_ok[col_at];
			lower_ok[col_at] = 1'b1;
		end
		for (k = 0; k < 3; k++) begin
			win[k * 3]     = win[k * 3 + 1];
			win[k * 3 + 1] = win[k * 3 + 2];
		end
		win[2] = two_up;
		win[5] = one_up;
		win[8] = px;
		if (row_at >= 2 && col_at >= 2) begin
			total = 0;
			for (k = 0; k < 9; k++)
				total += win[k];
			r.mean     = bf3_pkg::PIX_W'(total / 9);
			r.tag.row  = bf3_pkg::ROW_W'(row_at - 1);
			r.tag.col  = bf3_pkg::COL_W'(col_at - 1);
			r.tag.last = (row_at >= h - 1 && col_at >= w - 1);
			means_due.push_back(r);
		end
		// wrap column at line end, row at frame end
		if (col_at >= w - 1) begin
			col_at = 0;
			row_at = (row_at >= h - 1) ? 0 : row_at + 1;
		end else begin
			col_at++;
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic logic [bf3_pkg::PIX_W-1:0] next_pixel(input int unsigned flavor);
		case (flavor)
			1: return ($urandom_range(7, 0) != 0) ? 8'hFF : 8'($urandom_range(255, 0));
			2: return ($urandom_range(7, 0) != 0) ? 8'h00 : 8'($urandom_range(255, 0));
			3: return $urandom_range(1, 0) ? 8'hFF : 8'h00;
			default: return 8'($urandom_range(255, 0));
		endcase
	endfunction

	task automatic queue_pixels(input int unsigned count, input int unsigned flavor);
		repeat (count) pixels_todo.push_back(next_pixel(flavor));
	endtask

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(2, 0))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// Write both size registers on consecutive edges
	task automatic write_size(input logic [bf3_pkg::CFG_DAT_W-1:0] w_data,
		input logic [bf3_pkg::CFG_DAT_W-1:0] h_data);
		cfg_write <= 1'b1;
		cfg_index <= bf3_pkg::REG_IMAGE_WIDTH;
		cfg_data  <= w_data;
		@(posedge clk);
		cfg_index <= bf3_pkg::REG_IMAGE_HEIGHT;
		cfg_data  <= h_data;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Wait until every pixel is sent and every mean has arrived, then drain the pipe
	task automatic settle();
		do @(negedge clk);
		while (pixels_todo.size() != 0 || pix_if.valid || means_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// Pixel driver: offer queued pixels, hold while stalled, insert idle bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
			pix_if.pixel <= '0;
			gap_left = 0;
		end else if (pix_if.valid && !pix_if.ready) begin
			// hold the pending transaction
		end else if (gap_left != 0) begin
			pix_if.valid <= 1'b0;
			gap_left--;
		end else if (pixels_todo.size() == 0) begin
			pix_if.valid <= 1'b0;
		end else if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
			pix_if.valid <= 1'b0;
			gap_left = $urandom_range(13, 1) - 1;
		end else begin
			pix_if.valid <= 1'b1;
			pix_if.pixel <= pixels_todo.pop_front();
		end
	end

	// Result receiver: long hold on request, otherwise random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			res_if.ready <= 1'b0;
			hold_left--;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD - 1;
			res_if.ready <= 1'b0;
		end else if (stall_left != 0) begin
			res_if.ready <= 1'b0;
			stall_left--;
		end else if (snk_idle_pct != 0 && $urandom_range(99, 0) < snk_idle_pct) begin
			res_if.ready <= 1'b0;
			stall_left = $urandom_range(13, 1) - 1;
		end else begin
			res_if.ready <= 1'b1;
		end
	end

	// Scoreboard: track register writes, check each result transaction, predict each pixel
	always @(posedge clk) begin : scoreboard
		bf3_pkg::res_t want;
		if (!arst_n) begin
			line_w  = 12'd640;
			frame_h = 13'd480;
			win     = '{default: '0};
			row_at  = 0;
			col_at  = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == bf3_pkg::REG_IMAGE_WIDTH)
					line_w = cfg_data[bf3_pkg::WID_W-1:0];
				else
					frame_h = cfg_data;
			end
			if (res_if.valid && res_if.ready) begin
				if (means_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result at row %0d col %0d",
						res_if.out_row, res_if.out_col));
				end else begin
					want = means_due.pop_front();
					if (res_if.mean_value !== want.mean)
						report_mismatch($sformatf("mean at row %0d col %0d: got %0d, want %0d",
							want.tag.row, want.tag.col, res_if.mean_value, want.mean));
					if (res_if.out_row !== want.tag.row)
						report_mismatch($sformatf("row: got %0d, want %0d",
							res_if.out_row, want.tag.row));
					if (res_if.out_col !== want.tag.col)
						report_mismatch($sformatf("col at row %0d: got %0d, want %0d",
							want.tag.row, res_if.out_col, want.tag.col));
					if (res_if.frame_last !== want.tag.last)
						report_mismatch($sformatf("frame_last at row %0d col %0d: got %b, want %b",
							want.tag.row, want.tag.col, res_if.frame_last, want.tag.last));
				end
			end
			if (pix_if.valid && pix_if.ready)
				shift_in_pixel(pix_if.pixel);
		end
	end

	// Main sequence
	initial begin
		logic [bf3_pkg::PIX_W-1:0] lead_px [7];
		logic [bf3_pkg::PIX_W-1:0] tail_px [6];
		logic [bf3_pkg::CFG_DAT_W-1:0] wd, hd;
		int unsigned w_new, h_new, n, span, c, rand_count, round;
		bit ok;

		lead_px = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
		tail_px = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF};
		arst_n       <= 1'b0;
		cfg_write    <= 1'b0;
		cfg_index    <= bf3_pkg::REG_IMAGE_WIDTH;
		cfg_data     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame, width below range, all white
		write_size(13'h1000, 13'd3);
		@(negedge clk);
		src_idle_pct = 40;
		snk_idle_pct = 40;
		repeat (9) pixels_todo.push_back(8'hFF);
		settle();

		// Width with unused top bit, height below range, then narrow mid-frame
		write_size(13'h1005, 13'd1);
		@(negedge clk);
		foreach (lead_px[i]) pixels_todo.push_back(lead_px[i]);
		settle();
		write_size(13'd4, 13'd2);
		@(negedge clk);
		foreach (tail_px[i]) pixels_todo.push_back(tail_px[i]);
		settle();

		// Widest line, then tallest frame, each over part of a frame
		write_size(13'h1FFF, 13'd3);
		@(negedge clk);
		src_idle_pct = 15;
		snk_idle_pct = 15;
		queue_pixels(100, 0);
		settle();
		write_size(13'd2, 13'h1FFF);
		@(negedge clk);
		queue_pixels(180, 0);

		// Random small frames, partial frames and size changes between them
		rand_count = 0;
		round = 0;
		while (rand_count < 500) begin
			settle();
			wd = 13'($urandom_range(12, 3));
			case ($urandom_range(9, 0))
				0: wd = 13'($urandom_range(2, 0));
				1: wd = 13'($urandom_range(32, 13));
				default: ;
			endcase
			if ($urandom_range(9, 0) == 0)
				wd[12] = 1'b1;
			hd = ($urandom_range(7, 0) == 0) ? 13'($urandom_range(2, 0)) : 13'($urandom_range(8, 3));
			// widen mid-frame only over line store entries already written
			w_new = eff_width(wd[bf3_pkg::WID_W-1:0]);
			if (row_at != 0 && w_new > eff_width(line_w)) begin
				span = (w_new > col_at + 1) ? w_new : col_at + 1;
				ok = 1'b1;
				for (c = 0; c < span; c++)
					if (!(upper_ok[c] && lower_ok[c]))
						ok = 1'b0;
				if (!ok)
					wd = {1'b0, line_w};
			end
			write_size(wd, hd);
			@(negedge clk);
			// count pixels up to the end of the current frame
			w_new = eff_width(line_w);
			h_new = eff_height(frame_h);
			n = (col_at >= w_new - 1) ? 1 : w_new - col_at;
			if (row_at < h_new - 1)
				n += (h_new - 1 - row_at) * w_new;
			if (round == 1) begin
				// block the receiver while the sender keeps going
				while (n < 120)
					n += w_new * h_new;
				src_idle_pct = 0;
				snk_idle_pct = 0;
				hold_req++;
			end else begin
				if (n > 1 && $urandom_range(3, 0) == 0)
					n = $urandom_range(n - 1, 1);
				else if ($urandom_range(1, 0) != 0)
					n += w_new * h_new;
				if (rand_count >= 400) begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end else begin
					src_idle_pct = pick_idle_pct();
					snk_idle_pct = pick_idle_pct();
				end
			end
			queue_pixels(n, $urandom_range(3, 0));
			rand_count += n;
			round++;
		end

		settle();
		if (mismatches == 0 && means_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Run limit
	initial begin
		#30_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
